/* hdl/gpb_pkg.sv */
package gpb_pkg;

    // pin and field geometry
    localparam int PIN_COUNT_DEF   = 54;
    localparam int FUNC_FIELD_BITS = 3;
    localparam int PULL_FIELD_BITS = 2;
    localparam int FSEL_WORDS      = 6;
    localparam int PINS_PER_FSEL   = 10;
    localparam int FSEL_WIDTH      = FUNC_FIELD_BITS * PINS_PER_FSEL;
    localparam int FSEL_IDX_BITS   = $clog2(FSEL_WORDS);
    localparam int PULL_WORDS      = 2;

    localparam logic [FUNC_FIELD_BITS-1:0] FUNC_OUTPUT = FUNC_FIELD_BITS'(1);

    // register word offsets
    localparam logic [5:0] IDX_FSEL_FIRST = 6'd0;
    localparam logic [5:0] IDX_FSEL_LAST  = 6'd5;
    localparam logic [5:0] IDX_SET0       = 6'd7;
    localparam logic [5:0] IDX_SET1       = 6'd8;
    localparam logic [5:0] IDX_CLR0       = 6'd10;
    localparam logic [5:0] IDX_CLR1       = 6'd11;
    localparam logic [5:0] IDX_LEV0       = 6'd13;
    localparam logic [5:0] IDX_LEV1       = 6'd14;
    localparam logic [5:0] IDX_PULL0      = 6'd57;
    localparam logic [5:0] IDX_PULL1      = 6'd58;

    // decoded register group of one access
    typedef struct packed {
        logic is_fsel;
        logic is_set;
        logic is_clr;
        logic is_lev;
        logic is_pull;
        logic hi;
        logic err;
    } t_dec;

    // bits of a function-select word that belong to existing pins
    function automatic logic [FSEL_WIDTH-1:0] fsel_word_mask(
        input logic [FSEL_IDX_BITS-1:0] w,
        input int                       pin_count
    );
        logic [FSEL_WIDTH-1:0] m;
        int                    pin;
        m = '0;
        for (int k = 0; k < PINS_PER_FSEL; k++) begin
            pin = int'(w) * PINS_PER_FSEL + k;
            if (pin < pin_count) begin
                m[k*FUNC_FIELD_BITS +: FUNC_FIELD_BITS] = '1;
            end
        end
        return m;
    endfunction

endpackage

/* hdl/gpb_decode.sv */
module gpb_decode (
    input  logic [5:0]    i_word_index,
    output gpb_pkg::t_dec o_dec
);
    import gpb_pkg::*;

    // map word offset to register group and upper/lower half
    always_comb begin
        o_dec = '0;
        unique case (i_word_index) inside
            [IDX_FSEL_FIRST:IDX_FSEL_LAST]: o_dec.is_fsel = 1'b1;
            IDX_SET0, IDX_SET1: begin
                o_dec.is_set = 1'b1;
                o_dec.hi     = (i_word_index == IDX_SET1);
            end
            IDX_CLR0, IDX_CLR1: begin
                o_dec.is_clr = 1'b1;
                o_dec.hi     = (i_word_index == IDX_CLR1);
            end
            IDX_LEV0, IDX_LEV1: begin
                o_dec.is_lev = 1'b1;
                o_dec.hi     = (i_word_index == IDX_LEV1);
            end
            IDX_PULL0, IDX_PULL1: begin
                o_dec.is_pull = 1'b1;
                o_dec.hi      = (i_word_index == IDX_PULL1);
            end
            default: o_dec.err = 1'b1;
        endcase
    end

endmodule

/* hdl/gpb_regs.sv */
module gpb_regs #(
    parameter int PIN_COUNT = gpb_pkg::PIN_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_cmd,
    input  logic [5:0]    i_word_index,
    input  gpb_pkg::t_dec i_dec,
    input  logic [31:0]   i_write_data,
    input  logic [53:0]   i_pins_in,
    output logic [31:0]   o_read_data,
    output logic [63:0]   o_latch,
    output logic [63:0]   o_oe
);
    import gpb_pkg::*;

    localparam logic [63:0] PIN_MASK =
        (PIN_COUNT >= 64) ? '1 : ((64'd1 << PIN_COUNT) - 64'd1);
    localparam int FUNC_PINS = FSEL_WORDS * PINS_PER_FSEL;

    logic [FSEL_WIDTH-1:0] r_fsel [FSEL_WORDS];
    logic [PIN_COUNT-1:0]  r_latch;
    logic [31:0]           r_pull [PULL_WORDS];
    logic [PIN_COUNT-1:0]  n_latch;

    logic [63:0]              latch64;
    logic [63:0]              oe64;
    logic [63:0]              wr_shift;
    logic [63:0]              lev64;
    logic [FSEL_IDX_BITS-1:0] fsel_idx;

    assign fsel_idx = i_word_index[FSEL_IDX_BITS-1:0];
    assign latch64  = 64'(r_latch);
    assign wr_shift = i_dec.hi ? {i_write_data, 32'd0} : {32'd0, i_write_data};

    // output enables: one compare per pin that has a function field
    genvar p;
    generate
        for (p = 0; p < 64; p++) begin : g_oe
            if (p < PIN_COUNT && p < FUNC_PINS) begin : g_fn
                assign oe64[p] = (r_fsel[p / PINS_PER_FSEL]
                    [(p % PINS_PER_FSEL)*FUNC_FIELD_BITS +: FUNC_FIELD_BITS] == FUNC_OUTPUT);
            end else begin : g_in
                assign oe64[p] = 1'b0;
            end
        end
    endgenerate

    // next output latch from set and clear writes
    always_comb begin
        n_latch = r_latch;
        if (i_en && i_cmd && i_dec.is_set) begin
            n_latch = r_latch | PIN_COUNT'(wr_shift & PIN_MASK);
        end else if (i_en && i_cmd && i_dec.is_clr) begin
            n_latch = r_latch & ~PIN_COUNT'(wr_shift & PIN_MASK);
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < FSEL_WORDS; w++) begin
                r_fsel[w] <= '0;
            end
            r_pull[0] <= '0;
            r_pull[1] <= '0;
            r_latch   <= '0;
        end else begin
            r_latch <= n_latch;
            if (i_en && i_cmd && i_dec.is_fsel) begin
                r_fsel[fsel_idx] <= i_write_data[FSEL_WIDTH-1:0]
                                    & fsel_word_mask(fsel_idx, PIN_COUNT);
            end
            if (i_en && i_cmd && i_dec.is_pull) begin
                r_pull[i_dec.hi] <= i_write_data;
            end
        end
    end

    // pin levels: output pins show their latch, others the sampled input
    assign lev64 = (latch64 & oe64) | ((64'(i_pins_in) & PIN_MASK) & ~oe64);

    // read mux
    always_comb begin
        o_read_data = '0;
        if (!i_cmd) begin
            if (i_dec.is_fsel) begin
                o_read_data = 32'(r_fsel[fsel_idx]);
            end else if (i_dec.is_lev) begin
                o_read_data = i_dec.hi ? lev64[63:32] : lev64[31:0];
            end else if (i_dec.is_pull) begin
                o_read_data = r_pull[i_dec.hi];
            end
        end
    end

    assign o_latch = latch64;
    assign o_oe    = oe64;

endmodule

/* hdl/gpio_register_block_top.sv */
// GPIO register block for up to 54 pins (PIN_COUNT, 54 by default) on a 32-bit
// word bus. One access is taken in every cycle: busy never rises. The access
// is registered at the transfer edge, decoded and applied in the next cycle,
// and its result appears on the result ports in the cycle after that, marked by
// o_valid for exactly one cycle. The receiver cannot stall the block, so
// results must be captured when o_valid is high. Drive and output-enable ports
// always show the current latch and function selects; in the o_valid cycle
// they hold the state left by that access.
module gpio_register_block_top #(
    parameter int PIN_COUNT = gpb_pkg::PIN_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [5:0]  i_word_index,
    input  logic [31:0] i_write_data,
    input  logic [31:0] i_pins_in_low,
    input  logic [21:0] i_pins_in_high,
    output logic        o_valid,
    output logic [31:0] o_read_data,
    output logic        o_access_error,
    output logic [31:0] o_drive_low,
    output logic [21:0] o_drive_high,
    output logic [31:0] o_out_enable_low,
    output logic [21:0] o_out_enable_high
);
    import gpb_pkg::*;

    logic        r_in_valid;
    logic        r_cmd;
    logic [5:0]  r_word_index;
    logic [31:0] r_write_data;
    logic [53:0] r_pins_in;
    logic        r_out_valid;
    logic [31:0] r_read_data;
    logic        r_access_error;

    t_dec        dec;
    logic [31:0] read_data;
    logic [63:0] latch64;
    logic [63:0] oe64;

    assign busy = 1'b0;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd        <= i_cmd;
            r_word_index <= i_word_index;
            r_write_data <= i_write_data;
            r_pins_in    <= {i_pins_in_high, i_pins_in_low};
        end
    end

    gpb_decode u_decode (
        .i_word_index (r_word_index),
        .o_dec        (dec)
    );

    gpb_regs #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (r_in_valid),
        .i_cmd        (r_cmd),
        .i_word_index (r_word_index),
        .i_dec        (dec),
        .i_write_data (r_write_data),
        .i_pins_in    (r_pins_in),
        .o_read_data  (read_data),
        .o_latch      (latch64),
        .o_oe         (oe64)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_read_data    <= read_data;
            r_access_error <= dec.err;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_read_data       = r_read_data;
    assign o_access_error    = r_access_error;
    assign o_drive_low       = latch64[31:0];
    assign o_drive_high      = latch64[53:32];
    assign o_out_enable_low  = oe64[31:0];
    assign o_out_enable_high = oe64[53:32];

endmodule

/* hdl/gpb_checker.sv */
module gpb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_cmd,
    input logic        o_valid,
    input logic [31:0] o_read_data,
    input logic        o_access_error
);

    // every transfer yields a result, marked by o_valid
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("transfer produced no result");

    // no result without an earlier transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without a transfer");

    // write accesses return zero read data
    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_cmd, 2)) |-> (o_read_data == 32'd0))
        else $error("write returned nonzero read data");

    // unmapped accesses return zero read data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_access_error) |-> (o_read_data == 32'd0))
        else $error("unmapped access returned nonzero data");

endmodule

bind gpio_register_block_top gpb_checker u_gpb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_cmd          (i_cmd),
    .o_valid        (o_valid),
    .o_read_data    (o_read_data),
    .o_access_error (o_access_error)
);
